@@ src/unix_seconds_to_calendar_date_assert.svh @@
// Assertion macros for the unix seconds to calendar date block.
// Included by the top level; no other dependencies.
`ifndef UNIX_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define UNIX_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

`ifndef SYNTH
`define USTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`define USTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define USTC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define USTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/ustc_pkg.sv @@
// Shared types, constants and microcode table for the calendar date block.
// No dependencies.
`timescale 1ns / 1ps

package ustc_pkg;

    localparam int unsigned SECONDS_W = 32;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned DAYS_W    = 16;   // max day count 49710
    localparam int unsigned OUT_W     = 24;   // 21 bits of fields, padded to bytes

    // seconds / 86400 = (seconds >> 7) / 675; the / 675 is a reciprocal multiply,
    // exact for all 25-bit operands since 675 * DAY_RECIP - 2^35 = 607 < 2^10
    localparam int unsigned DAY_SHIFT   = 7;
    localparam int unsigned HI_W        = SECONDS_W - DAY_SHIFT;   // 25
    localparam int unsigned RECIP_W     = 26;
    localparam int unsigned PROD_W      = HI_W + RECIP_W;          // 51
    localparam int unsigned RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] DAY_RECIP = 26'd50903317;      // ceil(2^35 / 675)

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR   = 12'd1970;
    localparam logic [6:0]         EPOCH_MOD100 = 7'd70;
    localparam logic [8:0]         EPOCH_MOD400 = 9'd370;
    localparam logic [8:0]         DAYS_LEAP    = 9'd366;
    localparam logic [8:0]         DAYS_COMMON  = 9'd365;

    typedef logic [4:0] t_mlen;
    localparam t_mlen MONTH_LEN_TAB [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // sequencer step addresses
    typedef logic [2:0] t_step;
    localparam t_step STEP_LOAD  = 3'd0;
    localparam t_step STEP_DIV   = 3'd1;
    localparam t_step STEP_YEAR  = 3'd2;
    localparam t_step STEP_MONTH = 3'd3;
    localparam t_step STEP_EMIT  = 3'd4;

    // datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_LOAD  = 3'd0;
    localparam t_op OP_DIV   = 3'd1;
    localparam t_op OP_YEAR  = 3'd2;
    localparam t_op OP_MONTH = 3'd3;
    localparam t_op OP_EMIT  = 3'd4;
    localparam t_op OP_NOP   = 3'd7;

    // control word: operation, next step when condition holds, next step otherwise
    typedef struct packed {
        t_op   op;
        t_step jmp_t;
        t_step jmp_f;
    } t_uword;

    typedef struct packed {
        logic load;
        logic div;
        logic year;
        logic month;
    } t_dp_ctrl;

    typedef struct packed {
        logic year_ge;
        logic month_ge;
    } t_dp_stat;

    function automatic t_uword ucode_rom(input t_step s);
        t_uword w;
        case (s)
            STEP_LOAD:  w = '{op: OP_LOAD,  jmp_t: STEP_DIV,   jmp_f: STEP_LOAD};
            STEP_DIV:   w = '{op: OP_DIV,   jmp_t: STEP_YEAR,  jmp_f: STEP_DIV};
            STEP_YEAR:  w = '{op: OP_YEAR,  jmp_t: STEP_YEAR,  jmp_f: STEP_MONTH};
            STEP_MONTH: w = '{op: OP_MONTH, jmp_t: STEP_MONTH, jmp_f: STEP_EMIT};
            STEP_EMIT:  w = '{op: OP_EMIT,  jmp_t: STEP_LOAD,  jmp_f: STEP_EMIT};
            default:    w = '{op: OP_NOP,   jmp_t: STEP_LOAD,  jmp_f: STEP_LOAD};
        endcase
        return w;
    endfunction

    function automatic t_mlen month_len(input logic [MONTH_W-1:0] m, input logic leap);
        t_mlen l;
        logic [MONTH_W-1:0] idx;
        idx = m - 4'd1;
        if (m == 4'd0 || m > 4'd12) begin
            l = 5'd31;
        end else if (m == 4'd2 && leap) begin
            l = 5'd29;
        end else begin
            l = MONTH_LEN_TAB[idx];
        end
        return l;
    endfunction

endpackage

@@ src/ustc_datapath.sv @@
// Datapath of the calendar date block: reciprocal multiply for the day count,
// year and month subtract unit. Driven step by step by the sequencer; uses ustc_pkg.
`timescale 1ns / 1ps

module ustc_datapath import ustc_pkg::*; (
    input  logic                 i_clk,
    input  logic [SECONDS_W-1:0] i_seconds,
    input  t_dp_ctrl             i_ctrl,
    output t_dp_stat             o_stat,
    output logic [YEAR_W-1:0]    o_year,
    output logic [MONTH_W-1:0]   o_month,
    output logic [DAY_W-1:0]     o_day
);

    logic [HI_W-1:0]      r_secs_hi;
    logic [DAYS_W-1:0]    r_days;
    logic [YEAR_W-1:0]    r_year;
    logic [6:0]           r_mod100;
    logic [8:0]           r_mod400;
    logic [MONTH_W-1:0]   r_month;

    logic [PROD_W-1:0]    prod;
    logic                 leap;
    logic [8:0]           ylen;
    t_mlen                mlen;

    always_comb begin
        prod    = {{RECIP_W{1'b0}}, r_secs_hi} * {{HI_W{1'b0}}, DAY_RECIP};
        leap    = (r_year[1:0] == 2'd0) && (r_mod100 != 7'd0 || r_mod400 == 9'd0);
        ylen    = leap ? DAYS_LEAP : DAYS_COMMON;
        mlen    = month_len(r_month, leap);
        o_stat.year_ge  = r_days >= {7'd0, ylen};
        o_stat.month_ge = r_days >= {11'd0, mlen};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_secs_hi <= i_seconds[SECONDS_W-1:DAY_SHIFT];
            r_days    <= '0;
            r_year    <= EPOCH_YEAR;
            r_mod100  <= EPOCH_MOD100;
            r_mod400  <= EPOCH_MOD400;
            r_month   <= 4'd1;
        end
        if (i_ctrl.div) begin
            r_days <= prod[RECIP_SHIFT +: DAYS_W];
        end
        if (i_ctrl.year && o_stat.year_ge) begin
            r_days   <= r_days - {7'd0, ylen};
            r_year   <= r_year + 12'd1;
            r_mod100 <= (r_mod100 == 7'd99)  ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
        end
        if (i_ctrl.month && o_stat.month_ge) begin
            r_days  <= r_days - {11'd0, mlen};
            r_month <= r_month + 4'd1;
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_days[DAY_W-1:0] + 5'd1;

endmodule

@@ src/unix_seconds_to_calendar_date.sv @@
// Top level of the unix seconds to calendar date block: microcode sequencer,
// output register and stream handshakes. Uses ustc_pkg, ustc_datapath and the assert header.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// the Gregorian year, month (1-12) and day of month (1-31); leap seconds and time
// of day are ignored. One item is worked at a time: s_axis_tready is high only
// while the sequencer sits in its load step. An item passes a load step, a step
// for the day count (seconds / 86400 as a shift and a reciprocal multiply), a
// year step that takes off one year per pass until less than a year is left, a
// month step that does the same for months, and an emit step that moves the
// result into the output register once that is free. The year-by-year walk
// through the subtract unit is the longest part. The result waits in an output
// register, so the next item is accepted while it is still unclaimed.
`timescale 1ns / 1ps
`include "unix_seconds_to_calendar_date_assert.svh"

module unix_seconds_to_calendar_date import ustc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [11:0] year, [15:12] month, [20:16] day_of_month
);

    t_step              r_step, n_step;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    t_uword             uword;
    t_dp_ctrl           ctrl;
    t_dp_stat           stat;
    logic               cond;
    logic               slot_free;
    logic               emit;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;

    ustc_datapath u_dp (
        .i_clk     (i_clk),
        .i_seconds (s_axis_tdata),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .o_year    (year),
        .o_month   (month),
        .o_day     (day)
    );

    always_comb begin
        uword     = ucode_rom(r_step);
        slot_free = !r_out_valid || m_axis_tready;
        case (uword.op)
            OP_LOAD:  cond = s_axis_tvalid;
            OP_DIV:   cond = 1'b1;
            OP_YEAR:  cond = stat.year_ge;
            OP_MONTH: cond = stat.month_ge;
            OP_EMIT:  cond = slot_free;
            default:  cond = 1'b0;
        endcase
        n_step     = cond ? uword.jmp_t : uword.jmp_f;
        ctrl.load  = (uword.op == OP_LOAD) && s_axis_tvalid;
        ctrl.div   = (uword.op == OP_DIV);
        ctrl.year  = (uword.op == OP_YEAR);
        ctrl.month = (uword.op == OP_MONTH);
        emit       = (uword.op == OP_EMIT) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {3'd0, day, month, year};
        end
    end

    assign s_axis_tready = (uword.op == OP_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `USTC_ASSERT_NEXT(a_load_starts_div, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_step == STEP_DIV)
    `USTC_ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n, r_step == STEP_EMIT && slot_free, m_axis_tvalid && r_step == STEP_LOAD)
    `USTC_ASSERT_IMPL(a_month_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15:12] >= 4'd1 && m_axis_tdata[15:12] <= 4'd12)
    `USTC_ASSERT_IMPL(a_year_first, i_clk, i_rst_n, r_step == STEP_YEAR, month == 4'd1)

endmodule

@@ tb/unix_seconds_to_calendar_date_test.sv @@
// Self-checking testbench for unix_seconds_to_calendar_date: stream driver,
// monitor, civil-date predictor and stall watchdog. Depends only on the RTL.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date_test;

    localparam int unsigned SECS_IN_DAY   = 86400;
    localparam int unsigned LAST_DAY      = 49710;   // day count of 2106-02-07
    localparam int unsigned RANDOM_ITEMS  = 1150;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned HOLD_AT_ITEM  = 150;
    localparam int unsigned TAIL_CYCLES   = 200;
    localparam int unsigned STALL_LIMIT   = 6000;
    localparam int unsigned QUIET_FROM    = 20000;
    localparam int unsigned QUIET_TO      = 45000;
    localparam int unsigned IDLE_PERCENT  = 32;

    localparam logic [4:0] DAYS_OF_MONTH [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct {
        logic        drain;   // pause until all dates are back
        logic [31:0] secs;
    } stim_t;

    typedef struct {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } cal_date_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] seconds
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [11:0] year, [15:12] month, [20:16] day_of_month

    stim_t       seconds_q[$];
    cal_date_t   date_q[$];
    int unsigned items_sent = 0;
    int unsigned dates_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        gaps_on;

    // drive-side scratch
    logic        next_valid;
    stim_t       head;
    cal_date_t   got;
    cal_date_t   want;

    unix_seconds_to_calendar_date dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // no random idling inside this window of cycles
    assign gaps_on = !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);

    function automatic logic leap_year(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    function automatic cal_date_t civil_date(input logic [31:0] secs);
        cal_date_t   d;
        int unsigned days_left;
        int unsigned yr;
        int unsigned mo;
        int unsigned mlen;
        logic        done;
        days_left = secs / SECS_IN_DAY;
        yr = 1970;
        while (days_left >= (leap_year(yr) ? 366 : 365)) begin
            days_left -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        mo = 1;
        done = 1'b0;
        while (!done) begin
            mlen = DAYS_OF_MONTH[mo-1] + ((mo == 2 && leap_year(yr)) ? 1 : 0);
            if (mo == 12 || days_left < mlen) begin
                done = 1'b1;
            end else begin
                days_left -= mlen;
                mo++;
            end
        end
        d.year  = yr[11:0];
        d.month = mo[3:0];
        d.day   = days_left[4:0] + 5'd1;
        return d;
    endfunction

    // start of a given day plus an offset in seconds, clamped to 32 bits
    function automatic logic [31:0] at_day(input int unsigned d, input int unsigned off);
        longint unsigned v;
        v = longint'(d) * SECS_IN_DAY + off;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    task automatic push_secs(input logic [31:0] secs);
        stim_t s;
        s.drain = 1'b0;
        s.secs  = secs;
        seconds_q.push_back(s);
    endtask

    task automatic push_drain();
        stim_t s;
        s.drain = 1'b1;
        s.secs  = '0;
        seconds_q.push_back(s);
    endtask

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // driver: tvalid held until the transaction completes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                date_q.push_back(civil_date(s_axis_tdata));
                items_sent <= items_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                next_valid = 1'b0;
                if (seconds_q.size() > 0) begin
                    if (seconds_q[0].drain) begin
                        if (date_q.size() == 0) void'(seconds_q.pop_front());
                    end else if (!(gaps_on && $urandom_range(99) < IDLE_PERCENT)) begin
                        head = seconds_q.pop_front();
                        next_valid = 1'b1;
                        s_axis_tdata <= head.secs;
                    end
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // receiver: random idling plus one long hold-off to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            dates_seen <= dates_seen + 1;
            got.year  = m_axis_tdata[11:0];
            got.month = m_axis_tdata[15:12];
            got.day   = m_axis_tdata[20:16];
            if (date_q.size() == 0) begin
                report($sformatf("unexpected date %0d-%0d-%0d",
                                 got.year, got.month, got.day));
            end else begin
                want = date_q.pop_front();
                if (got.year !== want.year)
                    report($sformatf("year %0d, want %0d", got.year, want.year));
                if (got.month !== want.month)
                    report($sformatf("month %0d, want %0d", got.month, want.month));
                if (got.day !== want.day)
                    report($sformatf("day %0d, want %0d", got.day, want.day));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned kind;
        // edges of the input range and of days, years and months
        push_secs(32'd0);
        push_secs(32'd1);
        push_secs(at_day(0, 86399));
        push_secs(at_day(1, 0));
        push_secs(at_day(364, 86399));      // 1970-12-31, last second
        push_secs(at_day(365, 0));          // 1971-01-01
        push_secs(at_day(789, 0));          // 1972-02-29
        push_secs(at_day(790, 0));          // 1972-03-01
        push_secs(at_day(1094, 86399));     // 1972-12-30
        push_secs(at_day(1095, 0));         // 1972-12-31
        push_secs(at_day(11016, 43200));    // 2000-02-29, century leap year
        push_secs(at_day(11017, 0));        // 2000-03-01
        push_secs(at_day(47540, 86399));    // 2100-02-28, century common year
        push_secs(at_day(47541, 0));        // 2100-03-01
        push_secs(at_day(47481, 86399));    // 2099-12-31
        push_secs(32'h7FFF_FFFF);
        push_secs(32'h8000_0000);
        push_secs(32'hAAAA_AAAA);
        push_secs(32'h5555_5555);
        push_secs(at_day(LAST_DAY, 0));
        push_secs(32'hFFFF_FFFE);
        push_secs(32'hFFFF_FFFF);
        push_drain();

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) push_drain();
            kind = $urandom_range(99);
            if (kind < 55)
                push_secs($urandom);
            else if (kind < 80)
                push_secs(at_day($urandom_range(LAST_DAY), $urandom_range(1) ? 86399 : 0));
            else
                push_secs($urandom_range(400_000_000));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (seconds_q.size() != 0 || s_axis_tvalid || date_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (date_q.size() != 0)
            report($sformatf("%0d dates never arrived", date_q.size()));

        $display("covered %0d conversions (%0d dates checked): range and calendar edges,",
                 items_sent, dates_seen);
        $display("random instants, a long output hold-off and two full drains");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ustc_pkg.sv
src/ustc_datapath.sv
src/unix_seconds_to_calendar_date.sv
tb/unix_seconds_to_calendar_date_test.sv
